[src/keyswitch_inner_product_defines.svh]
// ============================================================================
// Key-switching inner product: assertion macros
// Shared macros for the port-level checker.
// ============================================================================
`ifndef KEYSWITCH_INNER_PRODUCT_DEFINES_SVH
`define KEYSWITCH_INNER_PRODUCT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KIP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KIP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/kip_pkg.sv]
// ============================================================================
// kip_pkg
// Types and constants shared by the key-switching inner product modules.
// ============================================================================
package kip_pkg;

    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_CUR_LIMBS = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_TOTAL_Q   = 1'b1;

    localparam logic KIND_LOAD = 1'b0;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_LATCH,
        OP_MAC,
        OP_RDMEM,
        OP_LOADX,
        OP_ZERO,
        OP_SHIFT1,
        OP_MULW,
        OP_SHIFT2,
        OP_MULQ,
        OP_SUB,
        OP_COR,
        OP_EXINIT,
        OP_EXSTEP,
        OP_STORE,
        OP_STOREREM,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        DST_AX,
        DST_BX,
        DST_W
    } t_dst;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAC,
        S_MAP,
        S_LOADX,
        S_SHIFT1,
        S_MULW,
        S_SHIFT2,
        S_MULQ,
        S_SUB,
        S_COR1,
        S_COR2,
        S_CHECK,
        S_EXACT,
        S_STOREREM,
        S_NEXT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       sel;
        logic [1:0] li;
        logic       lj;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic idx_ok;
        logic p_zero;
        logic x_ge_p;
    } t_status;

endpackage

[src/kip_ctrl.sv]
// ============================================================================
// kip_ctrl
// Sequencer for accumulation and Barrett reduction steps.
// ============================================================================
module kip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    output logic           o_in_stall,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    input  kip_pkg::t_status i_status,
    output kip_pkg::t_cmd  o_cmd
);
    import kip_pkg::*;

    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       r_sel, n_sel;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '{op: OP_NOP, sel: r_sel, li: 2'b00, lj: 1'b0};
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_LATCH;
                        n_cnt    = '0;
                        n_state  = S_MAC;
                    end
                end
            end
            S_MAC: begin
                // Counts 0..7 feed the multiplier; count 8 lets the last add land.
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[3]) begin
                    n_state = i_status.last ? S_MAP : S_IDLE;
                end else begin
                    o_cmd = '{op: OP_MAC, sel: r_cnt[2], li: {1'b0, r_cnt[1]}, lj: r_cnt[0]};
                end
            end
            S_MAP: begin
                o_cmd.op = OP_RDMEM;
                n_sel    = 1'b0;
                n_state  = S_LOADX;
            end
            S_LOADX: begin
                if (!i_status.idx_ok || i_status.p_zero) begin
                    o_cmd.op = OP_ZERO;
                    n_state  = S_NEXT;
                end else begin
                    o_cmd.op = OP_LOADX;
                    n_state  = S_SHIFT1;
                end
            end
            S_SHIFT1: begin
                o_cmd.op = OP_SHIFT1;
                n_cnt    = '0;
                n_state  = S_MULW;
            end
            S_MULW: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[3]) begin
                    n_state = S_SHIFT2;
                end else begin
                    o_cmd = '{op: OP_MULW, sel: r_sel, li: r_cnt[2:1], lj: r_cnt[0]};
                end
            end
            S_SHIFT2: begin
                o_cmd.op = OP_SHIFT2;
                n_cnt    = '0;
                n_state  = S_MULQ;
            end
            S_MULQ: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[3]) begin
                    n_state = S_SUB;
                end else begin
                    o_cmd = '{op: OP_MULQ, sel: r_sel, li: r_cnt[2:1], lj: r_cnt[0]};
                end
            end
            S_SUB: begin
                o_cmd.op = OP_SUB;
                n_state  = S_COR1;
            end
            S_COR1: begin
                o_cmd.op = OP_COR;
                n_state  = S_COR2;
            end
            S_COR2: begin
                o_cmd.op = OP_COR;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.x_ge_p) begin
                    o_cmd.op = OP_EXINIT;
                    n_cnt    = '0;
                    n_state  = S_EXACT;
                end else begin
                    o_cmd.op = OP_STORE;
                    n_state  = S_NEXT;
                end
            end
            S_EXACT: begin
                o_cmd.op = OP_EXSTEP;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    n_state = S_STOREREM;
                end
            end
            S_STOREREM: begin
                o_cmd.op = OP_STOREREM;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_LOADX;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/kip_datapath.sv]
// ============================================================================
// kip_datapath
// Accumulators, modulus table, shared 32x32 multiplier and reduction registers.
// ============================================================================
module kip_datapath #(
    parameter int MAX_MODULI = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kip_pkg::t_cmd  i_cmd,
    output kip_pkg::t_status o_status,
    input  logic           i_cfg_we,
    input  logic [kip_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [6:0]     i_cfg_data,
    input  logic [5:0]     i_limb,
    input  logic [63:0]    i_digit_value,
    input  logic [63:0]    i_key_ax,
    input  logic [63:0]    i_key_bx,
    input  logic           i_last_digit,
    input  logic [63:0]    i_modulus_value,
    input  logic [63:0]    i_reduction_ratio,
    input  logic [6:0]     i_reduction_shift,
    output logic [63:0]    o_result_ax,
    output logic [63:0]    o_result_bx,
    output logic [5:0]     o_out_limb
);
    import kip_pkg::*;

    localparam int AW = $clog2(MAX_MODULI);

    typedef struct packed {
        logic [63:0] prime;
        logic [63:0] ratio;
        logic [6:0]  shift;
    } t_entry;

    t_entry mem [MAX_MODULI];
    t_entry r_ent;

    logic [6:0]   r_cur_limbs, r_total_q;
    logic [63:0]  r_digit, r_kax, r_kbx;
    logic         r_last;
    logic [5:0]   r_limb;
    logic [127:0] r_acc_ax, r_acc_bx, n_acc_ax, n_acc_bx;
    logic [63:0]  r_prod;
    logic         r_pend;
    t_dst         r_pend_dst;
    logic [2:0]   r_pend_off;
    logic [127:0] r_t, n_t;
    logic [191:0] r_w, n_w;
    logic [127:0] r_x, n_x;
    logic [63:0]  r_rem, n_rem;
    logic [63:0]  r_res_ax, r_res_bx, n_res_ax, n_res_bx;
    logic         r_idx_ok;
    logic [63:0]  r_out_ax, r_out_bx;
    logic [5:0]   r_out_limb;

    logic [31:0]  mul_a, mul_b;
    logic         mul_en;
    t_dst         mul_dst;
    logic [2:0]   mul_off;
    logic [191:0] addend, acc_cur, acc_sum;
    logic signed [8:0] map_idx;
    logic         map_ok;
    logic [AW-1:0] rd_addr;
    logic [6:0]   pre_sh;
    logic [7:0]   post_sh;
    logic [64:0]  ex_t;
    logic         x_ge_p;

    function automatic logic [31:0] word32(input logic [127:0] v, input logic [1:0] k);
        word32 = v[{k, 5'b0} +: 32];
    endfunction

    // Output limb to table index; limbs past the active ones skip unused Q limbs.
    always_comb begin
        if ({1'b0, r_limb} >= r_cur_limbs) begin
            map_idx = $signed({3'b000, r_limb}) + $signed({2'b00, r_total_q})
                    - $signed({2'b00, r_cur_limbs});
        end else begin
            map_idx = $signed({3'b000, r_limb});
        end
        map_ok  = !map_idx[8] && (int'(map_idx[7:0]) < MAX_MODULI);
        rd_addr = AW'(map_idx[7:0]);
    end

    assign pre_sh  = (r_ent.shift == 7'd0) ? 7'd0 : r_ent.shift - 7'd1;
    assign post_sh = {1'b0, r_ent.shift} + 8'd1;
    assign x_ge_p  = (r_x[127:64] != 64'd0) || (r_x[63:0] >= r_ent.prime);
    assign ex_t    = {r_rem, r_x[127]};

    always_comb begin
        mul_en  = 1'b0;
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_dst = DST_W;
        mul_off = {1'b0, i_cmd.li} + {2'b00, i_cmd.lj};
        case (i_cmd.op)
            OP_MAC: begin
                mul_en  = 1'b1;
                mul_a   = word32({64'd0, r_digit}, i_cmd.li);
                mul_b   = word32({64'd0, i_cmd.sel ? r_kbx : r_kax}, {1'b0, i_cmd.lj});
                mul_dst = i_cmd.sel ? DST_BX : DST_AX;
            end
            OP_MULW: begin
                mul_en = 1'b1;
                mul_a  = word32(r_t, i_cmd.li);
                mul_b  = word32({64'd0, r_ent.ratio}, {1'b0, i_cmd.lj});
            end
            OP_MULQ: begin
                mul_en = 1'b1;
                mul_a  = word32(r_t, i_cmd.li);
                mul_b  = word32({64'd0, r_ent.prime}, {1'b0, i_cmd.lj});
            end
            default: mul_en = 1'b0;
        endcase
    end

    // One shifted partial product is added into its destination per cycle.
    always_comb begin
        addend = 192'(r_prod) << {r_pend_off, 5'b0};
        case (r_pend_dst)
            DST_AX:  acc_cur = {64'd0, r_acc_ax};
            DST_BX:  acc_cur = {64'd0, r_acc_bx};
            default: acc_cur = r_w;
        endcase
        acc_sum = acc_cur + addend;
    end

    always_comb begin
        n_acc_ax = r_acc_ax;
        n_acc_bx = r_acc_bx;
        n_t      = r_t;
        n_w      = r_w;
        n_x      = r_x;
        n_rem    = r_rem;
        n_res_ax = r_res_ax;
        n_res_bx = r_res_bx;
        case (i_cmd.op)
            OP_LOADX:  n_x = i_cmd.sel ? r_acc_bx : r_acc_ax;
            OP_SHIFT1: begin
                n_t = r_x >> pre_sh;
                n_w = '0;
            end
            OP_SHIFT2: begin
                n_t = 128'(r_w >> post_sh);
                n_w = '0;
            end
            OP_SUB:    n_x = r_x - r_w[127:0];
            OP_COR: begin
                if (x_ge_p) begin
                    n_x = r_x - {64'd0, r_ent.prime};
                end
            end
            OP_EXINIT: n_rem = '0;
            OP_EXSTEP: begin
                n_x = r_x << 1;
                if (ex_t >= {1'b0, r_ent.prime}) begin
                    n_rem = 64'(ex_t - {1'b0, r_ent.prime});
                end else begin
                    n_rem = ex_t[63:0];
                end
            end
            OP_ZERO: begin
                if (i_cmd.sel) n_res_bx = '0;
                else           n_res_ax = '0;
            end
            OP_STORE: begin
                if (i_cmd.sel) n_res_bx = r_x[63:0];
                else           n_res_ax = r_x[63:0];
            end
            OP_STOREREM: begin
                if (i_cmd.sel) n_res_bx = r_rem;
                else           n_res_ax = r_rem;
            end
            OP_EMIT: begin
                n_acc_ax = '0;
                n_acc_bx = '0;
            end
            default: n_x = r_x;
        endcase
        if (r_pend) begin
            case (r_pend_dst)
                DST_AX:  n_acc_ax = acc_sum[127:0];
                DST_BX:  n_acc_bx = acc_sum[127:0];
                default: n_w      = acc_sum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_limbs <= 7'd1;
            r_total_q   <= 7'd1;
            r_acc_ax    <= '0;
            r_acc_bx    <= '0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CUR_LIMBS) r_cur_limbs <= i_cfg_data;
                if (i_cfg_index == CFG_TOTAL_Q)   r_total_q   <= i_cfg_data;
            end
            r_acc_ax <= n_acc_ax;
            r_acc_bx <= n_acc_bx;
            r_pend   <= mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_w      <= n_w;
        r_x      <= n_x;
        r_rem    <= n_rem;
        r_res_ax <= n_res_ax;
        r_res_bx <= n_res_bx;
        if (mul_en) begin
            r_prod     <= mul_a * mul_b;
            r_pend_dst <= mul_dst;
            r_pend_off <= mul_off;
        end
        if (i_cmd.op == OP_LATCH) begin
            r_digit <= i_digit_value;
            r_kax   <= i_key_ax;
            r_kbx   <= i_key_bx;
            r_last  <= i_last_digit;
            r_limb  <= i_limb;
        end
        if (i_cmd.op == OP_RDMEM) begin
            r_idx_ok <= map_ok;
            r_ent    <= mem[rd_addr];
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out_ax   <= r_res_ax;
            r_out_bx   <= r_res_bx;
            r_out_limb <= r_limb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && int'(i_limb) < MAX_MODULI) begin
            mem[AW'(i_limb)] <= '{prime: i_modulus_value, ratio: i_reduction_ratio,
                                  shift: i_reduction_shift};
        end
    end

    assign o_status = '{last: r_last, idx_ok: r_idx_ok,
                        p_zero: (r_ent.prime == 64'd0), x_ge_p: x_ge_p};
    assign o_result_ax = r_out_ax;
    assign o_result_bx = r_out_bx;
    assign o_out_limb  = r_out_limb;

endmodule

[src/keyswitch_inner_product.sv]
// A load word is written to the modulus table on acceptance; a data word is latched and its
// partial products are accumulated. A closing data word adds Barrett reduction of each sum,
// plus the bit-serial exact remainder when needed. One word is in work at a time; the single
// shared 32x32 multiplier sets the rate. The output register frees the input side.
// Reset (i_rst_n low, synchronous) clears control, accumulators and sets both limb
// registers to 1; the modulus table holds no reset value and must be loaded first.
// ============================================================================
// keyswitch_inner_product
// RNS key-switching inner product with Barrett reduction, top level.
// ============================================================================
module keyswitch_inner_product #(
    parameter int MAX_MODULI = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [5:0]  i_limb,
    input  logic [63:0] i_digit_value,
    input  logic [63:0] i_key_ax,
    input  logic [63:0] i_key_bx,
    input  logic        i_last_digit,
    input  logic [63:0] i_modulus_value,
    input  logic [63:0] i_reduction_ratio,
    input  logic [6:0]  i_reduction_shift,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_ax,
    output logic [63:0] o_result_bx,
    output logic [5:0]  o_out_limb,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [kip_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import kip_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    kip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kip_datapath #(.MAX_MODULI(MAX_MODULI)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid & o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_limb            (i_limb),
        .i_digit_value     (i_digit_value),
        .i_key_ax          (i_key_ax),
        .i_key_bx          (i_key_bx),
        .i_last_digit      (i_last_digit),
        .i_modulus_value   (i_modulus_value),
        .i_reduction_ratio (i_reduction_ratio),
        .i_reduction_shift (i_reduction_shift),
        .o_result_ax       (o_result_ax),
        .o_result_bx       (o_result_bx),
        .o_out_limb        (o_out_limb)
    );

endmodule

[src/kip_checker.sv]
// ============================================================================
// kip_checker
// Port-level checks for the key-switching inner product.
// ============================================================================
`include "keyswitch_inner_product_defines.svh"

module kip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_result_ax
);
    // An accepted data word always stalls the input while the block works on it.
    `KIP_ASSERT_NEXT(a_data_busy, i_in_valid && !o_in_stall && i_kind, o_in_stall, "data word did not stall input")
    // A new result only appears while the block is busy with a word.
    `KIP_ASSERT_IMPL(a_result_from_work, $rose(o_out_valid), $past(o_in_stall), "result without work")
    // A waiting result word stays valid and its ax half is held.
    `KIP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_ax), "stalled result changed")

endmodule

bind keyswitch_inner_product kip_checker u_kip_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Key-switching inner product testbench
// Drives load and data words with random gaps and output stalls, predicts the
// Barrett-reduced sums in a scoreboard, and checks every result word in order.
// ============================================================================
module tb;
    import kip_pkg::*;

    localparam logic KIND_DATA = ~KIND_LOAD;
    localparam int   TABLE_DEPTH = 64;
    localparam int   DOG_LIMIT = 20000;
    localparam int   SETTLE_CYCLES = 400;
    localparam int   HOLD_CYCLES = 3000;
    localparam int   SEG_WORDS = 215;

    typedef struct {
        logic        kind;
        logic [5:0]  limb;
        logic [63:0] digit;
        logic [63:0] kax;
        logic [63:0] kbx;
        logic        last;
        logic [63:0] prime;
        logic [63:0] ratio;
        logic [6:0]  shift;
    } word_t;

    typedef struct {
        logic [63:0] rax;
        logic [63:0] rbx;
        logic [5:0]  limb;
    } sum_t;

    class sum_scoreboard;
        logic [6:0]   cur_limbs;
        logic [6:0]   q_limbs;
        logic [127:0] acc_ax;
        logic [127:0] acc_bx;
        logic [63:0]  prime_tab[TABLE_DEPTH];
        logic [63:0]  ratio_tab[TABLE_DEPTH];
        logic [6:0]   shift_tab[TABLE_DEPTH];
        sum_t         sums_due[$];
        int           errors;

        function new();
            cur_limbs = 7'd1;
            q_limbs = 7'd1;
            acc_ax = '0;
            acc_bx = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [6:0] val);
            if (idx == CFG_CUR_LIMBS) cur_limbs = val;
            else if (idx == CFG_TOTAL_Q) q_limbs = val;
        endfunction

        function logic [63:0] reduce(logic [127:0] x, logic [63:0] p, logic [63:0] k,
                                     logic [6:0] s);
            logic [191:0] prod;
            logic [127:0] t;
            logic [127:0] q;
            logic [127:0] r;
            int           pre;
            if (p == 64'd0) return 64'd0;
            pre = (s == 7'd0) ? 0 : int'(s) - 1;
            t = x >> pre;
            prod = {64'd0, t} * {128'd0, k};
            prod = prod >> (int'(s) + 1);
            q = prod[127:0];
            r = x - q * {64'd0, p};
            repeat (2) if (r >= {64'd0, p}) r = r - {64'd0, p};
            // A table entry whose ratio does not match its prime can leave r large.
            if (r >= {64'd0, p}) r = r % {64'd0, p};
            return r[63:0];
        endfunction

        function void note_input(word_t w);
            int   idx;
            sum_t e;
            if (w.kind == KIND_LOAD) begin
                prime_tab[w.limb] = w.prime;
                ratio_tab[w.limb] = w.ratio;
                shift_tab[w.limb] = w.shift;
                return;
            end
            acc_ax = acc_ax + {64'd0, w.digit} * {64'd0, w.kax};
            acc_bx = acc_bx + {64'd0, w.digit} * {64'd0, w.kbx};
            if (!w.last) return;
            idx = int'(w.limb);
            if (int'(w.limb) >= int'(cur_limbs)) idx = idx + int'(q_limbs) - int'(cur_limbs);
            e.rax = '0;
            e.rbx = '0;
            e.limb = w.limb;
            if (idx >= 0 && idx < TABLE_DEPTH) begin
                e.rax = reduce(acc_ax, prime_tab[idx], ratio_tab[idx], shift_tab[idx]);
                e.rbx = reduce(acc_bx, prime_tab[idx], ratio_tab[idx], shift_tab[idx]);
            end
            sums_due.push_back(e);
            acc_ax = '0;
            acc_bx = '0;
        endfunction

        function void check_result(logic [63:0] rax, logic [63:0] rbx, logic [5:0] limb);
            sum_t e;
            if (sums_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word: ax=%h bx=%h limb=%0d",
                                           rax, rbx, limb);
                return;
            end
            e = sums_due.pop_front();
            if (rax !== e.rax || rbx !== e.rbx || limb !== e.limb) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected ax=%h bx=%h limb=%0d, got ax=%h bx=%h limb=%0d",
                             e.rax, e.rbx, e.limb, rax, rbx, limb);
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic [5:0]  i_limb = '0;
    logic [63:0] i_digit_value = '0;
    logic [63:0] i_key_ax = '0;
    logic [63:0] i_key_bx = '0;
    logic        i_last_digit = 1'b0;
    logic [63:0] i_modulus_value = '0;
    logic [63:0] i_reduction_ratio = '0;
    logic [6:0]  i_reduction_shift = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_result_ax;
    logic [63:0] o_result_bx;
    logic [5:0]  o_out_limb;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;

    keyswitch_inner_product dut (.*);

    sum_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_on = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) i_out_stall <= hold_on || ($urandom_range(99) < stall_pct);

    // Long receiver hold-off so the block backs up and stalls its input.
    initial forever begin
        wait (hold_req);
        hold_req = 1'b0;
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_on = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_result_ax, o_result_bx, o_out_limb);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= DOG_LIMIT) begin
                $display("keyswitch_inner_product verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edgy64();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // flavor 0: matched Barrett constants, 1: arbitrary entry, 2: prime near 2^64
    function automatic word_t make_load(int slot, int flavor);
        word_t w;
        int    b;
        w.kind = KIND_LOAD;
        w.limb = slot[5:0];
        w.digit = rand64();
        w.kax = rand64();
        w.kbx = rand64();
        w.last = $urandom_range(1);
        case (flavor)
            0: begin
                b = $urandom_range(2, 62);
                w.prime = (rand64() & ((64'd1 << b) - 64'd1)) | (64'd1 << (b - 1)) | 64'd1;
                w.shift = b[6:0];
                w.ratio = 64'((128'd1 << (2 * b)) / {64'd0, w.prime});
            end
            1: begin
                w.prime = rand64();
                if (w.prime < 64'd2) w.prime = 64'd2;
                w.ratio = rand64();
                w.shift = $urandom_range(127);
            end
            default: begin
                w.prime = '1 - 64'($urandom_range(1000));
                w.shift = 7'd63;
                w.ratio = 64'((128'd1 << 126) / {64'd0, w.prime});
            end
        endcase
        return w;
    endfunction

    function automatic word_t make_digit(logic [5:0] limb, logic last);
        word_t w;
        w.kind = KIND_DATA;
        w.limb = limb;
        w.digit = edgy64();
        w.kax = edgy64();
        w.kbx = edgy64();
        w.last = last;
        w.prime = rand64();
        w.ratio = rand64();
        w.shift = $urandom_range(127);
        return w;
    endfunction

    task automatic send_word(word_t w);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind = w.kind;
        i_limb = w.limb;
        i_digit_value = w.digit;
        i_key_ax = w.kax;
        i_key_bx = w.kbx;
        i_last_digit = w.last;
        i_modulus_value = w.prime;
        i_reduction_ratio = w.ratio;
        i_reduction_shift = w.shift;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
        @(negedge i_clk);
    endtask

    task automatic send_sum(logic [5:0] limb, int n, logic [63:0] d, logic [63:0] k);
        word_t w;
        for (int i = 0; i < n; i++) begin
            w = make_digit(limb, i == n - 1);
            w.digit = d;
            w.kax = k;
            w.kbx = ~k;
            send_word(w);
        end
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [6:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits for every due result, then lets any word still in work finish.
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int    cfg_cur[8] = '{64, 1, 64, 32, 5, 63, 0, 1};
        int    cfg_q[8] = '{64, 64, 1, 7, 40, 63, 0, 1};
        int    idle_of[4] = '{0, 83, 0, 31};
        int    stall_of[4] = '{0, 0, 83, 31};
        int    sent;
        int    n;
        word_t w;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < TABLE_DEPTH; i++) send_word(make_load(i, i % 3));

        // Directed: widest operands, wrapping sums, zero sums, zero shift.
        send_sum(6'd0, 1, '1, '1);
        send_sum(6'd63, 4, '1, '1);
        send_sum(6'd1, 1, 64'd0, '1);
        send_sum(6'd2, 3, '1, 64'd0);
        w = make_load(5, 0);
        w.shift = 7'd0;
        send_word(w);
        send_sum(6'd5, 2, '1, 64'h8000_0000_0000_0001);
        send_sum(6'd62, 2, 64'd1, '1);
        send_sum(6'd3, 1, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);

        for (int seg = 0; seg < 8; seg++) begin
            settle();
            if (cfg_cur[seg] == 0) begin
                cfg_cur[seg] = $urandom_range(1, 64);
                cfg_q[seg] = $urandom_range(1, 64);
            end
            write_reg(CFG_CUR_LIMBS, cfg_cur[seg][6:0]);
            write_reg(CFG_TOTAL_Q, cfg_q[seg][6:0]);
            idle_pct = idle_of[seg % 4];
            stall_pct = stall_of[seg % 4];
            sent = 0;
            while (sent < SEG_WORDS) begin
                if (seg == 0 && sent == 60) hold_req = 1'b1;
                if ($urandom_range(9) == 0) begin
                    send_word(make_load($urandom_range(63), $urandom_range(2)));
                    sent++;
                end else begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        send_word(make_digit($urandom_range(63), i == n - 1));
                        sent++;
                    end
                end
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("keyswitch_inner_product verification clean");
        end else begin
            $display("keyswitch_inner_product verification failed");
        end
        $finish;
    end
endmodule
